FILE: design/path_interval_cover_set_macros.svh
// ----------------------------------------------------------------------------
// Path interval cover set assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef PATH_INTERVAL_COVER_SET_MACROS_SVH
`define PATH_INTERVAL_COVER_SET_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PICS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PICS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/pics_pkg.sv
// ----------------------------------------------------------------------------
// Path interval cover set package
// Shared types, codes and default sizes.
// ----------------------------------------------------------------------------
package pics_pkg;

    localparam int S_SEGMENTS_DEF = 64;
    localparam int T_SEGMENTS_DEF = 32;
    localparam int PATH_MAX_DEF   = 16;

    localparam int COORD_W = 16;
    localparam int INDEX_W = 6;
    localparam int ITEM_W  = 7;
    localparam int PCNT_W  = 5;
    localparam int CCNT_W  = 6;
    localparam int CFG_W   = 6;

    localparam logic [1:0] FUNC_LOAD_S = 2'd0;
    localparam logic [1:0] FUNC_LOAD_T = 2'd1;
    localparam logic [1:0] FUNC_PATH   = 2'd2;

    localparam logic [1:0] KIND_PART  = 2'd0;
    localparam logic [1:0] KIND_COVER = 2'd1;
    localparam logic [1:0] KIND_MARK  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SREAD,
        ST_SCAN,
        ST_DRAIN,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic [COORD_W-1:0] start;
        logic [COORD_W-1:0] finish;
    } t_interval;

    typedef struct packed {
        logic [1:0]         func;
        logic [INDEX_W-1:0] table_index;
        logic [COORD_W-1:0] interval_start;
        logic [COORD_W-1:0] interval_finish;
        logic [ITEM_W-1:0]  segment_number;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ITEM_W-1:0] item_value;
        logic [PCNT_W-1:0] part_count;
        logic [CCNT_W-1:0] cover_count;
        logic              path_overflow;
        logic              bad_segment;
        logic              last;
    } t_out_item;

endpackage

FILE: design/pics_table_store.sv
// ----------------------------------------------------------------------------
// Interval table store
// One memory holding the S intervals followed by the T intervals.
// ----------------------------------------------------------------------------
module pics_table_store
    import pics_pkg::*;
#(
    parameter int DEPTH = S_SEGMENTS_DEF + T_SEGMENTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_interval     i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_interval     o_rdata
);

    t_interval r_mem [DEPTH];
    t_interval r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/pics_list_store.sv
// ----------------------------------------------------------------------------
// Part and cover list store
// One memory holding the part list followed by the covered list.
// ----------------------------------------------------------------------------
module pics_list_store
    import pics_pkg::*;
#(
    parameter int DEPTH = PATH_MAX_DEF + T_SEGMENTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [ITEM_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [ITEM_W-1:0] o_rdata
);

    logic [ITEM_W-1:0] r_mem [DEPTH];
    logic [ITEM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/pics_ctrl.sv
// ----------------------------------------------------------------------------
// Path interval cover set sequencer
// Handles loads, runs the overlap scan per path element and drains the lists.
// ----------------------------------------------------------------------------
module pics_ctrl
    import pics_pkg::*;
#(
    parameter int S_SEGMENTS = S_SEGMENTS_DEF,
    parameter int T_SEGMENTS = T_SEGMENTS_DEF,
    parameter int PATH_MAX   = PATH_MAX_DEF,
    parameter int TA_W       = $clog2(S_SEGMENTS + T_SEGMENTS),
    parameter int LA_W       = $clog2(PATH_MAX + T_SEGMENTS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_in_item          i_item,
    output logic              o_busy,
    input  logic              i_cfg_valid,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output logic              o_cfg_ready,
    output logic              o_tbl_we,
    output logic [TA_W-1:0]   o_tbl_waddr,
    output t_interval         o_tbl_wdata,
    output logic [TA_W-1:0]   o_tbl_raddr,
    input  t_interval         i_tbl_rdata,
    output logic              o_lst_we,
    output logic [LA_W-1:0]   o_lst_waddr,
    output logic [ITEM_W-1:0] o_lst_wdata,
    output logic [LA_W-1:0]   o_lst_raddr,
    input  logic [ITEM_W-1:0] i_lst_rdata,
    output logic              o_res_valid,
    output t_out_item         o_res
);

    localparam int TI_W = (T_SEGMENTS > 1) ? $clog2(T_SEGMENTS) : 1;
    localparam int TC_W = $clog2(T_SEGMENTS + 1);
    localparam int PF_W = $clog2(PATH_MAX + 1);
    localparam int EP_W = $clog2(PATH_MAX + T_SEGMENTS + 1);

    t_state                r_state, n_state;
    logic [PF_W-1:0]       r_part_fill, n_part_fill;
    logic [TC_W-1:0]       r_cover_fill, n_cover_fill;
    logic [T_SEGMENTS-1:0] r_seen, n_seen;
    logic                  r_err_ov, n_err_ov;
    logic                  r_err_bad, n_err_bad;
    logic [TI_W-1:0]       r_ci, n_ci;
    logic [EP_W-1:0]       r_ep, n_ep;
    logic [COORD_W-1:0]    r_ss, n_ss;
    logic [COORD_W-1:0]    r_se, n_se;
    logic                  r_ov, n_ov;
    logic [1:0]            r_okind, n_okind;
    logic                  r_olast, n_olast;
    logic [CFG_W-1:0]      r_t_count;

    logic [TC_W-1:0]       lim;
    logic [EP_W-1:0]       total;
    logic                  hit;
    logic                  in_parts;
    logic                  is_last;

    assign lim = (32'(r_t_count) > T_SEGMENTS) ? TC_W'(T_SEGMENTS) : TC_W'(r_t_count);
    assign total = EP_W'(r_part_fill) + EP_W'(r_cover_fill);
    assign in_parts = 32'(r_ep) < 32'(r_part_fill);
    assign is_last = (32'(r_ep) + 32'd1) == 32'(total);

    assign hit = ((i_tbl_rdata.start <= r_ss) && (r_ss <= i_tbl_rdata.finish)) ||
                 ((i_tbl_rdata.start <= r_se) && (r_se <= i_tbl_rdata.finish)) ||
                 ((i_tbl_rdata.start >= r_ss) && (r_se >= i_tbl_rdata.finish));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_part_fill  <= '0;
            r_cover_fill <= '0;
            r_seen       <= '0;
            r_err_ov     <= 1'b0;
            r_err_bad    <= 1'b0;
            r_ci         <= '0;
            r_ep         <= '0;
            r_ov         <= 1'b0;
            r_okind      <= KIND_PART;
            r_olast      <= 1'b0;
            r_t_count    <= '0;
        end else begin
            r_state      <= n_state;
            r_part_fill  <= n_part_fill;
            r_cover_fill <= n_cover_fill;
            r_seen       <= n_seen;
            r_err_ov     <= n_err_ov;
            r_err_bad    <= n_err_bad;
            r_ci         <= n_ci;
            r_ep         <= n_ep;
            r_ov         <= n_ov;
            r_okind      <= n_okind;
            r_olast      <= n_olast;
            if (i_cfg_valid && o_cfg_ready) begin
                r_t_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ss <= n_ss;
        r_se <= n_se;
    end

    always_comb begin
        n_state      = r_state;
        n_part_fill  = r_part_fill;
        n_cover_fill = r_cover_fill;
        n_seen       = r_seen;
        n_err_ov     = r_err_ov;
        n_err_bad    = r_err_bad;
        n_ci         = r_ci;
        n_ep         = r_ep;
        n_ss         = r_ss;
        n_se         = r_se;
        n_ov         = 1'b0;
        n_okind      = r_okind;
        n_olast      = 1'b0;
        o_tbl_we     = 1'b0;
        o_tbl_waddr  = '0;
        o_tbl_wdata  = '{start: i_item.interval_start, finish: i_item.interval_finish};
        o_tbl_raddr  = '0;
        o_lst_we     = 1'b0;
        o_lst_waddr  = '0;
        o_lst_wdata  = i_item.segment_number;
        o_lst_raddr  = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (i_item.func)
                        FUNC_LOAD_S: begin
                            if (32'(i_item.table_index) < S_SEGMENTS) begin
                                o_tbl_we    = 1'b1;
                                o_tbl_waddr = TA_W'(i_item.table_index);
                            end
                        end
                        FUNC_LOAD_T: begin
                            if (32'(i_item.table_index) < T_SEGMENTS) begin
                                o_tbl_we    = 1'b1;
                                o_tbl_waddr = TA_W'(S_SEGMENTS + 32'(i_item.table_index));
                            end
                        end
                        FUNC_PATH: begin
                            if (i_item.segment_number == '0) begin
                                n_ep    = '0;
                                n_state = ST_DRAIN;
                            end else if (32'(i_item.segment_number) > S_SEGMENTS) begin
                                n_err_bad = 1'b1;
                            end else if (32'(r_part_fill) >= PATH_MAX) begin
                                n_err_ov = 1'b1;
                            end else begin
                                o_lst_we    = 1'b1;
                                o_lst_waddr = LA_W'(r_part_fill);
                                n_part_fill = r_part_fill + 1'b1;
                                o_tbl_raddr = TA_W'(32'(i_item.segment_number) - 32'd1);
                                if (lim != '0) begin
                                    n_state = ST_SREAD;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SREAD: begin
                n_ss        = i_tbl_rdata.start;
                n_se        = i_tbl_rdata.finish;
                n_ci        = '0;
                o_tbl_raddr = TA_W'(S_SEGMENTS);
                n_state     = ST_SCAN;
            end
            ST_SCAN: begin
                if (hit && !r_seen[r_ci] && (32'(r_cover_fill) < T_SEGMENTS)) begin
                    n_seen[r_ci] = 1'b1;
                    o_lst_we     = 1'b1;
                    o_lst_waddr  = LA_W'(PATH_MAX + 32'(r_cover_fill));
                    o_lst_wdata  = ITEM_W'(32'(r_ci) + 32'd1);
                    n_cover_fill = r_cover_fill + 1'b1;
                end
                if ((32'(r_ci) + 32'd1) >= 32'(lim)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_ci        = r_ci + 1'b1;
                    o_tbl_raddr = TA_W'(S_SEGMENTS + 32'(r_ci) + 32'd1);
                end
            end
            ST_DRAIN: begin
                n_ov = 1'b1;
                if (total == '0) begin
                    n_okind = KIND_MARK;
                    n_olast = 1'b1;
                    n_state = ST_CLEAR;
                end else begin
                    if (in_parts) begin
                        o_lst_raddr = LA_W'(r_ep);
                        n_okind     = KIND_PART;
                    end else begin
                        o_lst_raddr = LA_W'(PATH_MAX + 32'(r_ep) - 32'(r_part_fill));
                        n_okind     = KIND_COVER;
                    end
                    n_olast = is_last;
                    n_ep    = r_ep + 1'b1;
                    if (is_last) begin
                        n_state = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR: begin
                n_part_fill  = '0;
                n_cover_fill = '0;
                n_seen       = '0;
                n_err_ov     = 1'b0;
                n_err_bad    = 1'b0;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_res_valid = r_ov;

    always_comb begin
        o_res.kind          = r_okind;
        o_res.item_value    = (r_okind == KIND_MARK) ? '0 : i_lst_rdata;
        o_res.part_count    = PCNT_W'(r_part_fill);
        o_res.cover_count   = CCNT_W'(r_cover_fill);
        o_res.path_overflow = r_err_ov;
        o_res.bad_segment   = r_err_bad;
        o_res.last          = r_olast;
    end

endmodule

FILE: design/path_interval_cover_set.sv
// Interval loads and dropped path elements leave the sequencer idle; busy stays low.
// A path element reads its S interval and scans min(t_segment_count, T_SEGMENTS)
// T entries, one T entry per cycle from the table memory; with none it stays idle.
// A path end drains the result beats from the list memory, one per cycle, then clears;
// the first beat strobes once the drain state has registered the result valid.
// Synchronous active-low reset clears the fills, flags, cover marks and config.
// ----------------------------------------------------------------------------
// Path interval cover set
// Top level joining the sequencer, the interval table and the list memory.
// ----------------------------------------------------------------------------
module path_interval_cover_set
    import pics_pkg::*;
#(
    parameter int S_SEGMENTS = S_SEGMENTS_DEF,
    parameter int T_SEGMENTS = T_SEGMENTS_DEF,
    parameter int PATH_MAX   = PATH_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_in_item         i_item,
    output logic             o_busy,
    input  logic             i_cfg_valid,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_cfg_ready,
    output logic             o_res_valid,
    output t_out_item        o_res
);

    localparam int TDEPTH = S_SEGMENTS + T_SEGMENTS;
    localparam int LDEPTH = PATH_MAX + T_SEGMENTS;
    localparam int TA_W   = $clog2(TDEPTH);
    localparam int LA_W   = $clog2(LDEPTH);

    logic              tbl_we;
    logic [TA_W-1:0]   tbl_waddr;
    t_interval         tbl_wdata;
    logic [TA_W-1:0]   tbl_raddr;
    t_interval         tbl_rdata;
    logic              lst_we;
    logic [LA_W-1:0]   lst_waddr;
    logic [ITEM_W-1:0] lst_wdata;
    logic [LA_W-1:0]   lst_raddr;
    logic [ITEM_W-1:0] lst_rdata;

    pics_ctrl #(
        .S_SEGMENTS (S_SEGMENTS),
        .T_SEGMENTS (T_SEGMENTS),
        .PATH_MAX   (PATH_MAX),
        .TA_W       (TA_W),
        .LA_W       (LA_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_item      (i_item),
        .o_busy      (o_busy),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_tbl_we    (tbl_we),
        .o_tbl_waddr (tbl_waddr),
        .o_tbl_wdata (tbl_wdata),
        .o_tbl_raddr (tbl_raddr),
        .i_tbl_rdata (tbl_rdata),
        .o_lst_we    (lst_we),
        .o_lst_waddr (lst_waddr),
        .o_lst_wdata (lst_wdata),
        .o_lst_raddr (lst_raddr),
        .i_lst_rdata (lst_rdata),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    pics_table_store #(
        .DEPTH (TDEPTH),
        .AW    (TA_W)
    ) u_tables (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    pics_list_store #(
        .DEPTH (LDEPTH),
        .AW    (LA_W)
    ) u_lists (
        .i_clk   (i_clk),
        .i_we    (lst_we),
        .i_waddr (lst_waddr),
        .i_wdata (lst_wdata),
        .i_raddr (lst_raddr),
        .o_rdata (lst_rdata)
    );

endmodule

FILE: design/pics_checker.sv
// ----------------------------------------------------------------------------
// Path interval cover set port checker
// Watches the result beats on the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
`include "path_interval_cover_set_macros.svh"

module pics_checker
    import pics_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_busy,
    input logic      i_res_valid,
    input t_out_item i_res
);

    `PICS_ASSERT_IMP(a_beat_while_busy, i_clk, i_rst_n, i_res_valid, i_busy, "result beat while not busy")
    `PICS_ASSERT_NXT(a_run_contiguous, i_clk, i_rst_n, i_res_valid && !i_res.last, i_res_valid, "gap inside a result run")
    `PICS_ASSERT_NXT(a_run_ends, i_clk, i_rst_n, i_res_valid && i_res.last, !i_res_valid, "beat right after the last beat")
    `PICS_ASSERT_IMP(a_marker_alone, i_clk, i_rst_n, i_res_valid && (i_res.kind == KIND_MARK), i_res.last && (i_res.part_count == '0) && (i_res.cover_count == '0), "marker beat with content")

endmodule

bind path_interval_cover_set pics_checker u_pics_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_busy      (o_busy),
    .i_res_valid (o_res_valid),
    .i_res       (o_res)
);

FILE: bench/path_interval_cover_set_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path interval cover set testbench
// Loads the S and T interval tables, then sends paths of S segments under
// several T search counts, with random gaps on the command side. An
// in-bench predictor builds the part, cover and marker beats for every path end, and
// each result beat is checked field by field against the oldest one queued.
// ----------------------------------------------------------------------------
module path_interval_cover_set_tb;
    import pics_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int unsigned SETTLE_CYCLES = 60;
    localparam int unsigned RUN_LIMIT = 400000;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_start;
    t_in_item         i_item;
    logic             o_busy;
    logic             i_cfg_valid;
    logic [CFG_W-1:0] i_cfg_data;
    logic             o_cfg_ready;
    logic             o_res_valid;
    t_out_item        o_res;

    logic [COORD_W-1:0]        s_lo [S_SEGMENTS_DEF];
    logic [COORD_W-1:0]        s_hi [S_SEGMENTS_DEF];
    logic [COORD_W-1:0]        t_lo [T_SEGMENTS_DEF];
    logic [COORD_W-1:0]        t_hi [T_SEGMENTS_DEF];
    logic [ITEM_W-1:0]         route_parts [$];
    logic [INDEX_W-1:0]        covered_t [$];
    logic [T_SEGMENTS_DEF-1:0] covered_mask = '0;
    logic                      route_overflow = 1'b0;
    logic                      route_bad = 1'b0;
    logic [CFG_W-1:0]          t_search_count = '0;
    t_out_item                 pending_reports [$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    bit          no_idle = 1'b0;

    path_interval_cover_set i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_item     (i_item),
        .o_busy     (o_busy),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_cfg_ready(o_cfg_ready),
        .o_res_valid(o_res_valid),
        .o_res      (o_res)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("path_interval_cover_set verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n === 1'b1 && o_res_valid !== 1'b0) begin
            if (pending_reports.size() == 0) begin
                report_mismatch("beat with nothing expected", 32'(o_res.item_value), '0);
            end else begin
                want = pending_reports.pop_front();
                if (o_res_valid !== 1'b1)
                    report_mismatch("res_valid", 32'(o_res_valid), 32'd1);
                if (o_res.kind !== want.kind)
                    report_mismatch("kind", 32'(o_res.kind), 32'(want.kind));
                if (o_res.item_value !== want.item_value)
                    report_mismatch("item_value", 32'(o_res.item_value),
                                    32'(want.item_value));
                if (o_res.part_count !== want.part_count)
                    report_mismatch("part_count", 32'(o_res.part_count),
                                    32'(want.part_count));
                if (o_res.cover_count !== want.cover_count)
                    report_mismatch("cover_count", 32'(o_res.cover_count),
                                    32'(want.cover_count));
                if (o_res.path_overflow !== want.path_overflow)
                    report_mismatch("path_overflow", 32'(o_res.path_overflow),
                                    32'(want.path_overflow));
                if (o_res.bad_segment !== want.bad_segment)
                    report_mismatch("bad_segment", 32'(o_res.bad_segment),
                                    32'(want.bad_segment));
                if (o_res.last !== want.last)
                    report_mismatch("last", 32'(o_res.last), 32'(want.last));
            end
        end
    end

    // Tracks tables, the open path and its cover set; queues the beats of a path end.
    function automatic void predict_reports(input t_in_item it);
        t_out_item          beat;
        int unsigned        lim;
        int unsigned        total;
        int unsigned        n;
        logic [COORD_W-1:0] ss;
        logic [COORD_W-1:0] se;
        logic [COORD_W-1:0] ts;
        logic [COORD_W-1:0] te;
        case (it.func)
            FUNC_LOAD_S: begin
                s_lo[it.table_index] = it.interval_start;
                s_hi[it.table_index] = it.interval_finish;
            end
            FUNC_LOAD_T: begin
                if (it.table_index < T_SEGMENTS_DEF) begin
                    t_lo[it.table_index] = it.interval_start;
                    t_hi[it.table_index] = it.interval_finish;
                end
            end
            FUNC_PATH: begin
                if (it.segment_number == 0) begin
                    beat.part_count    = PCNT_W'(route_parts.size());
                    beat.cover_count   = CCNT_W'(covered_t.size());
                    beat.path_overflow = route_overflow;
                    beat.bad_segment   = route_bad;
                    total = route_parts.size() + covered_t.size();
                    n = 0;
                    foreach (route_parts[i]) begin
                        beat.kind       = KIND_PART;
                        beat.item_value = route_parts[i];
                        n++;
                        beat.last       = (n == total);
                        pending_reports.push_back(beat);
                    end
                    foreach (covered_t[i]) begin
                        beat.kind       = KIND_COVER;
                        beat.item_value = ITEM_W'(covered_t[i]) + 1'b1;
                        n++;
                        beat.last       = (n == total);
                        pending_reports.push_back(beat);
                    end
                    if (total == 0) begin
                        beat.kind       = KIND_MARK;
                        beat.item_value = '0;
                        beat.last       = 1'b1;
                        pending_reports.push_back(beat);
                    end
                    route_parts.delete();
                    covered_t.delete();
                    covered_mask   = '0;
                    route_overflow = 1'b0;
                    route_bad      = 1'b0;
                end else if (it.segment_number > S_SEGMENTS_DEF) begin
                    route_bad = 1'b1;
                end else if (route_parts.size() >= PATH_MAX_DEF) begin
                    route_overflow = 1'b1;
                end else begin
                    route_parts.push_back(it.segment_number);
                    ss = s_lo[it.segment_number - 1];
                    se = s_hi[it.segment_number - 1];
                    lim = (32'(t_search_count) < T_SEGMENTS_DEF) ? 32'(t_search_count)
                                                                 : T_SEGMENTS_DEF;
                    for (int i = 0; i < lim; i++) begin
                        ts = t_lo[i];
                        te = t_hi[i];
                        if (((ts <= ss && ss <= te) || (ts <= se && se <= te) ||
                             (ts >= ss && se >= te)) && !covered_mask[i]) begin
                            covered_mask[i] = 1'b1;
                            covered_t.push_back(INDEX_W'(i));
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_interval rand_span();
        t_interval   span;
        int unsigned base;
        if ($urandom_range(0, 11) == 0) begin
            span.start  = COORD_W'($urandom);
            span.finish = COORD_W'($urandom);
        end else begin
            base        = $urandom_range(1, 3000);
            span.start  = COORD_W'(base);
            span.finish = COORD_W'(base + $urandom_range(0, 500));
        end
        return span;
    endfunction

    function automatic t_in_item make_item(input logic [1:0] func,
                                           input logic [INDEX_W-1:0] idx,
                                           input t_interval span,
                                           input logic [ITEM_W-1:0] seg);
        t_in_item it;
        it.func            = func;
        it.table_index     = idx;
        it.interval_start  = span.start;
        it.interval_finish = span.finish;
        it.segment_number  = seg;
        return it;
    endfunction

    // Start stays high across back-to-back beats; it is lowered for a gap or when waiting idle.
    task automatic send_item(input t_in_item it);
        int unsigned gap;
        if (i_start !== 1'b1)
            i_start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        predict_reports(it);
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_segment(input int unsigned seg);
        send_item(make_item(FUNC_PATH, INDEX_W'($urandom), rand_span(), ITEM_W'(seg)));
    endtask

    task automatic send_noise(output bit counted);
        int unsigned  r;
        logic [INDEX_W-1:0] idx;
        r = $urandom_range(0, 2);
        idx = INDEX_W'($urandom);
        counted = 1'b1;
        if (r == 0) begin
            send_item(make_item(FUNC_LOAD_S, idx, rand_span(), ITEM_W'($urandom)));
        end else if (r == 1) begin
            counted = (idx < T_SEGMENTS_DEF);
            send_item(make_item(FUNC_LOAD_T, idx, rand_span(), ITEM_W'($urandom)));
        end else begin
            counted = 1'b0;
            send_item(make_item(FUNC_UNUSED, idx, rand_span(), ITEM_W'($urandom)));
        end
    endtask

    task automatic wait_idle();
        if (i_start === 1'b1)
            i_start <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_search_count(input logic [CFG_W-1:0] count);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= count;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        t_search_count = count;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_table_load();
        t_interval span;
        write_search_count(CFG_W'(T_SEGMENTS_DEF));
        for (int i = 0; i < S_SEGMENTS_DEF; i++) begin
            span = rand_span();
            if (i == 0) begin
                span.start  = 16'd1;
                span.finish = 16'hFFFF;
            end else if (i == 1) begin
                span.start  = 16'd0;
                span.finish = 16'd0;
            end else if (i == S_SEGMENTS_DEF - 1) begin
                span.start  = 16'hFFFF;
                span.finish = 16'hFFFF;
            end
            send_item(make_item(FUNC_LOAD_S, INDEX_W'(i), span, ITEM_W'($urandom)));
        end
        for (int i = 0; i < T_SEGMENTS_DEF; i++) begin
            span = rand_span();
            if (i == 0) begin
                span.start  = 16'd1;
                span.finish = 16'd1;
            end else if (i == T_SEGMENTS_DEF - 1) begin
                span.start  = 16'hFFFF;
                span.finish = 16'hFFFF;
            end
            send_item(make_item(FUNC_LOAD_T, INDEX_W'(i), span, ITEM_W'($urandom)));
        end
    endtask

    task automatic test_path_basics();
        send_segment(0);
        send_segment(1);
        send_segment(S_SEGMENTS_DEF);
        send_segment(1);
        send_segment(S_SEGMENTS_DEF + 1);
        send_segment(0);
        send_item(make_item(FUNC_LOAD_T, INDEX_W'(40), rand_span(), '1));
        send_item(make_item(FUNC_UNUSED, '1, rand_span(), '1));
        send_segment(127);
        send_segment(0);
    endtask

    task automatic test_path_overflow();
        for (int i = 0; i <= PATH_MAX_DEF; i++)
            send_segment($urandom_range(1, S_SEGMENTS_DEF));
        send_segment(0);
    endtask

    task automatic run_random_paths(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        bit          counted;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 12) begin
                send_noise(counted);
                sent += counted;
            end else begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20)
                                                  : $urandom_range(0, 5);
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(0, 19))
                        0: send_segment($urandom_range(S_SEGMENTS_DEF + 1, 127));
                        1: send_noise(counted);
                        default: send_segment($urandom_range(1, S_SEGMENTS_DEF));
                    endcase
                    sent++;
                end
                send_segment(0);
                sent++;
            end
        end
    endtask

    task automatic test_search_counts();
        logic [CFG_W-1:0] counts [5];
        counts = '{CFG_W'(0), CFG_W'(1), CFG_W'(63), CFG_W'(31),
                   CFG_W'($urandom_range(2, 30))};
        foreach (counts[i]) begin
            wait_idle();
            write_search_count(counts[i]);
            run_random_paths(8);
        end
    endtask

    task automatic test_random_traffic();
        wait_idle();
        write_search_count(CFG_W'(T_SEGMENTS_DEF));
        no_idle = 1'b1;
        run_random_paths(12);
        no_idle = 1'b0;
        run_random_paths(18);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_table_load();
        test_path_basics();
        test_path_overflow();
        test_search_counts();
        test_random_traffic();
        wait_idle();
        if (mismatch_count == 0) begin
            $display("path_interval_cover_set verification clean");
        end else begin
            $display("path_interval_cover_set verification failed");
        end
        $finish;
    end

endmodule
